FILE: sv/brf_pkg.sv
// Shared types and constants for the circular byte FIFO.
package brf_pkg;

	// Default number of byte entries in the ring
	localparam int DEPTH_DEFAULT = 8192;

	// Request codes; code 7 is unused and changes nothing
	typedef enum logic [2:0] {
		REQ_PUSH      = 3'd0,
		REQ_POP       = 3'd1,
		REQ_PEEK      = 3'd2,
		REQ_STAGE     = 3'd3,
		REQ_ADV_REAR  = 3'd4,
		REQ_ADV_FRONT = 3'd5,
		REQ_CLEAR     = 3'd6
	} req_code_t;

	// One incoming request
	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  data_in;
		logic [12:0] offset;
		logic [13:0] count;
	} req_t;

	// One result
	typedef struct packed {
		logic [7:0]  data_out;
		logic        done_res;
		logic [13:0] moved;
		logic [13:0] used_count;
		logic [13:0] free_count;
		logic [13:0] direct_enqueue;
		logic [13:0] direct_dequeue;
	} res_t;

	// Per-request outcome handed from the controller to the result stage
	typedef struct packed {
		logic        done;
		logic        rd;
		logic [13:0] moved;
	} op_info_t;

	// Occupancy and contiguous runs taken from the pointer registers
	typedef struct packed {
		logic [13:0] used;
		logic [13:0] free;
		logic [13:0] de;
		logic [13:0] dd;
	} status_t;

endpackage

FILE: sv/brf_ram.sv
// Byte store: single-port-per-direction synchronous RAM, registered read.
module brf_ram #(
	parameter int DEPTH = brf_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port: hold data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/brf_ctrl.sv
// Pointer and fill-count control: request decode, address generation, status.
module brf_ctrl #(
	parameter int DEPTH = brf_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  brf_pkg::req_t      req,
	output logic               ram_we,
	output logic               ram_re,
	output logic [AW-1:0]      ram_addr,
	output logic [7:0]         ram_wdata,
	output brf_pkg::op_info_t  op,
	output brf_pkg::status_t   status
);
	import brf_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > 14) ? CW : 14;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CW-1:0] fill_q;

	logic [CW-1:0] free_c;
	logic [EW-1:0] fill_e;
	logic [EW-1:0] free_e;
	logic [EW-1:0] off_e;
	logic [EW-1:0] cnt_e;
	logic [CW-1:0] moved_c;
	logic [CW-1:0] amt_c;
	logic [CW-1:0] fill_nx;
	logic [CW-1:0] acc_off;
	logic [AW-1:0] acc_base;
	logic [AW-1:0] adv_base;
	logic [AW-1:0] adv_ptr;
	logic          done_c;
	logic          rd_c;
	logic          we_c;
	logic          upd_rd;
	logic          upd_wr;
	logic          clr_c;
	logic          acc_rd;
	logic          acc_off_en;
	logic [CW-1:0] de_c;
	logic [CW-1:0] dd_c;

	// Pointer plus amount, wrapped once; the sum stays below twice the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
			input logic [CW-1:0] n);
		logic [CW:0] s;
		s = (CW+1)'(p) + (CW+1)'(n);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return AW'(s);
	endfunction

	assign free_c = DEPTH_C - fill_q;
	assign fill_e = EW'(fill_q);
	assign free_e = EW'(free_c);
	assign off_e  = EW'(req.offset);
	assign cnt_e  = EW'(req.count);

	// Decode the request against the current occupancy
	always_comb begin
		done_c  = 1'b0;
		rd_c    = 1'b0;
		we_c    = 1'b0;
		upd_rd  = 1'b0;
		upd_wr  = 1'b0;
		clr_c   = 1'b0;
		moved_c = '0;
		amt_c   = CW'(1);
		fill_nx = fill_q;
		unique case (req.req_type)
			REQ_PUSH: begin
				if (fill_q < DEPTH_C) begin
					done_c  = 1'b1;
					we_c    = 1'b1;
					upd_wr  = 1'b1;
					fill_nx = fill_q + CW'(1);
				end
			end
			REQ_POP: begin
				if (fill_q != '0) begin
					done_c  = 1'b1;
					rd_c    = 1'b1;
					upd_rd  = 1'b1;
					fill_nx = fill_q - CW'(1);
				end
			end
			REQ_PEEK: begin
				if (off_e < fill_e) begin
					done_c = 1'b1;
					rd_c   = 1'b1;
				end
			end
			REQ_STAGE: begin
				if (off_e < free_e) begin
					done_c = 1'b1;
					we_c   = 1'b1;
				end
			end
			REQ_ADV_REAR: begin
				moved_c = (cnt_e < free_e) ? CW'(cnt_e) : free_c;
				amt_c   = moved_c;
				done_c  = 1'b1;
				upd_wr  = 1'b1;
				fill_nx = fill_q + moved_c;
			end
			REQ_ADV_FRONT: begin
				moved_c = (cnt_e < fill_e) ? CW'(cnt_e) : fill_q;
				amt_c   = moved_c;
				done_c  = 1'b1;
				upd_rd  = 1'b1;
				fill_nx = fill_q - moved_c;
			end
			REQ_CLEAR: begin
				done_c  = 1'b1;
				clr_c   = 1'b1;
				fill_nx = '0;
			end
			default: begin
			end
		endcase
	end

	// Access address: read pointer for pop and peek, write pointer otherwise
	assign acc_rd     = (req.req_type == REQ_POP) || (req.req_type == REQ_PEEK);
	assign acc_off_en = (req.req_type == REQ_PEEK) || (req.req_type == REQ_STAGE);
	assign acc_base   = acc_rd ? rd_ptr_q : wr_ptr_q;
	assign acc_off    = acc_off_en ? CW'(off_e) : '0;
	assign ram_addr   = wrap_add(acc_base, acc_off);
	assign ram_wdata  = req.data_in;
	assign ram_we     = accept && we_c;
	assign ram_re     = accept && rd_c;

	// Advance whichever pointer the request moves
	assign adv_base = upd_rd ? rd_ptr_q : wr_ptr_q;
	assign adv_ptr  = wrap_add(adv_base, amt_c);

	assign op.done  = done_c;
	assign op.rd    = rd_c;
	assign op.moved = 14'(moved_c);

	// Hold pointers and fill count; update on an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			if (clr_c) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
			end else begin
				if (upd_rd) begin
					rd_ptr_q <= adv_ptr;
				end
				if (upd_wr) begin
					wr_ptr_q <= adv_ptr;
				end
			end
			fill_q <= fill_nx;
		end
	end

	// Contiguous runs up to the wrap point
	always_comb begin
		if (fill_q == '0) begin
			de_c = DEPTH_C - CW'(wr_ptr_q);
			dd_c = '0;
		end else if (fill_q >= DEPTH_C) begin
			de_c = '0;
			dd_c = DEPTH_C - CW'(rd_ptr_q);
		end else if (rd_ptr_q < wr_ptr_q) begin
			de_c = DEPTH_C - CW'(wr_ptr_q);
			dd_c = CW'(wr_ptr_q) - CW'(rd_ptr_q);
		end else begin
			de_c = CW'(rd_ptr_q) - CW'(wr_ptr_q);
			dd_c = DEPTH_C - CW'(rd_ptr_q);
		end
	end

	assign status.used = 14'(fill_q);
	assign status.free = 14'(free_c);
	assign status.de   = 14'(de_c);
	assign status.dd   = 14'(dd_c);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count above depth");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(rd_ptr_q) < DEPTH) && (int'(wr_ptr_q) < DEPTH))
		else $error("pointer beyond last entry");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store read and written by one request");

endmodule

FILE: sv/byte_ring_fifo.sv
// Top level of the circular byte FIFO: handshake, result stage and output register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  brf_pkg::req_t
//   res      out        res_valid / res_ready  brf_pkg::res_t
//
// Sustains one request per cycle while results are taken; a result is built in
// the result stage from the captured outcome and the store's registered read data.
// Reset clears pointers, fill count and both valid flags, not the store itself;
// the user must read an entry only after it was written; the block does not enforce it.
// A stalled result holds the output register; one more request then waits
// in the result stage and further requests see req_ready low.
module byte_ring_fifo #(
	parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  brf_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_ready,
	output brf_pkg::res_t res_data
);
	import brf_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic          accept;
	logic          out_free;
	logic          adv_s1;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	op_info_t      op;
	status_t       status;

	logic          valid_s1;
	op_info_t      op_s1;
	logic          res_valid_q;
	res_t          res_q;

	// Handshake: take a request while the result stage is empty or can drain
	assign out_free = !res_valid_q || res_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;
	assign accept   = req_valid && req_ready;

	brf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req_data),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.op        (op),
		.status    (status)
	);

	brf_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Capture the outcome, then build the result once the read data lands;
	// pointer status then reflects this request and no later one
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
		end
		if (adv_s1) begin
			res_q.data_out       <= op_s1.rd ? ram_rdata : 8'd0;
			res_q.done_res       <= op_s1.done;
			res_q.moved          <= op_s1.moved;
			res_q.used_count     <= status.used;
			res_q.free_count     <= status.free;
			res_q.direct_enqueue <= status.de;
			res_q.direct_dequeue <= status.dd;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost before result stage");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.done_res || (res_data.data_out == 8'd0)))
		else $error("data on a refused request");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (14'(res_data.used_count + res_data.free_count) == 14'(DEPTH)))
		else $error("used and free counts disagree with depth");

endmodule

FILE: sim/tb.sv
// Testbench for byte_ring_fifo: directed and randomised requests checked against a ring predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	localparam int RING_DEPTH = DEPTH_DEFAULT;
	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int IDLE_PCT = 27;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res_data;

	// Predictor copy of the ring, with a flag for each byte that was written
	logic [7:0] ring_bytes [RING_DEPTH];
	bit ring_written [RING_DEPTH];
	int rd_ptr = 0;
	int wr_ptr = 0;
	int fill = 0;
	res_t awaited_results [$];

	int req_gap_pct = IDLE_PCT;
	int res_stall_pct = IDLE_PCT;
	int hold_cycles_req = 0;
	int hold_left = 0;
	int requests_sent = 0;
	int failures = 0;
	int quiet_cycles = 0;

	byte_ring_fifo dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic req_t make_req(input logic [2:0] code, input int din, input int off,
			input int cnt);
		req_t r;
		r.req_type = code;
		r.data_in = 8'(din);
		r.offset = 13'(off);
		r.count = 14'(cnt);
		return r;
	endfunction

	// Apply one accepted request to the ring copy and queue the result it must produce
	task automatic ring_apply(input req_t r);
		res_t e;
		int free_sp;
		int step;
		int idx;
		e = '0;
		free_sp = RING_DEPTH - fill;
		case (r.req_type)
			REQ_PUSH: begin
				if (fill < RING_DEPTH) begin
					ring_bytes[wr_ptr] = r.data_in;
					ring_written[wr_ptr] = 1'b1;
					wr_ptr = (wr_ptr + 1) % RING_DEPTH;
					fill++;
					e.done_res = 1'b1;
				end
			end
			REQ_POP: begin
				if (fill > 0) begin
					e.data_out = ring_bytes[rd_ptr];
					rd_ptr = (rd_ptr + 1) % RING_DEPTH;
					fill--;
					e.done_res = 1'b1;
				end
			end
			REQ_PEEK: begin
				if (int'(r.offset) < fill) begin
					e.data_out = ring_bytes[(rd_ptr + int'(r.offset)) % RING_DEPTH];
					e.done_res = 1'b1;
				end
			end
			REQ_STAGE: begin
				if (int'(r.offset) < free_sp) begin
					idx = (wr_ptr + int'(r.offset)) % RING_DEPTH;
					ring_bytes[idx] = r.data_in;
					ring_written[idx] = 1'b1;
					e.done_res = 1'b1;
				end
			end
			REQ_ADV_REAR: begin
				step = (int'(r.count) < free_sp) ? int'(r.count) : free_sp;
				wr_ptr = (wr_ptr + step) % RING_DEPTH;
				fill += step;
				e.moved = 14'(step);
				e.done_res = 1'b1;
			end
			REQ_ADV_FRONT: begin
				step = (int'(r.count) < fill) ? int'(r.count) : fill;
				rd_ptr = (rd_ptr + step) % RING_DEPTH;
				fill -= step;
				e.moved = 14'(step);
				e.done_res = 1'b1;
			end
			REQ_CLEAR: begin
				rd_ptr = 0;
				wr_ptr = 0;
				fill = 0;
				e.done_res = 1'b1;
			end
			default: ;
		endcase

		// Occupancy and contiguous runs up to the wrap point
		e.used_count = 14'(fill);
		e.free_count = 14'(RING_DEPTH - fill);
		if (fill == 0) begin
			e.direct_enqueue = 14'(RING_DEPTH - wr_ptr);
			e.direct_dequeue = '0;
		end else if (fill >= RING_DEPTH) begin
			e.direct_enqueue = '0;
			e.direct_dequeue = 14'(RING_DEPTH - rd_ptr);
		end else if (rd_ptr < wr_ptr) begin
			e.direct_enqueue = 14'(RING_DEPTH - wr_ptr);
			e.direct_dequeue = 14'(wr_ptr - rd_ptr);
		end else begin
			e.direct_enqueue = 14'(rd_ptr - wr_ptr);
			e.direct_dequeue = 14'(RING_DEPTH - rd_ptr);
		end
		awaited_results.push_back(e);
	endtask

	// Offer one request, idling at random first, and hold it until taken
	task automatic send_request(input req_t r);
		while ($urandom_range(0, 99) < req_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		ring_apply(r);
		requests_sent++;
	endtask

	// Drop valid and wait for every queued result
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endtask

	// Pick a random request; steer reads away from bytes that were never written
	function automatic req_t random_request();
		req_t r;
		int pick;
		int free_sp;
		pick = $urandom_range(0, 99);
		free_sp = RING_DEPTH - fill;
		r.data_in = 8'($urandom);
		r.offset = 13'($urandom);
		if ($urandom_range(0, 4) == 0)
			r.count = 14'($urandom_range(0, RING_DEPTH));
		else
			r.count = 14'($urandom_range(0, 12));
		if (pick < 28) begin
			r.req_type = REQ_PUSH;
		end else if (pick < 48) begin
			r.req_type = REQ_POP;
		end else if (pick < 63) begin
			r.req_type = REQ_PEEK;
			if (fill > 0 && $urandom_range(0, 3) != 0)
				r.offset = 13'($urandom_range(0, fill - 1));
		end else if (pick < 76) begin
			r.req_type = REQ_STAGE;
			if (free_sp > 0 && $urandom_range(0, 3) != 0)
				r.offset = 13'($urandom_range(0, free_sp - 1));
		end else if (pick < 86) begin
			r.req_type = REQ_ADV_REAR;
		end else if (pick < 95) begin
			r.req_type = REQ_ADV_FRONT;
		end else if (pick < 98) begin
			r.req_type = REQ_CLEAR;
		end else begin
			r.req_type = REQ_UNUSED;
		end
		if ((r.req_type == REQ_POP && fill > 0 && !ring_written[rd_ptr]) ||
				(r.req_type == REQ_PEEK && int'(r.offset) < fill &&
				!ring_written[(rd_ptr + int'(r.offset)) % RING_DEPTH])) begin
			r.req_type = REQ_ADV_FRONT;
			r.count = 14'($urandom_range(1, fill));
		end
		return r;
	endfunction

	// Empty, refused, full and wrapping cases, field extremes and every request code
	task automatic test_directed_edges();
		send_request(make_req(REQ_UNUSED, 8'hFF, 8191, 8192));
		send_request(make_req(REQ_POP, 8'h00, 0, 0));
		send_request(make_req(REQ_PEEK, 8'h00, 0, 0));
		send_request(make_req(REQ_ADV_FRONT, 8'h00, 0, 8192));
		send_request(make_req(REQ_ADV_REAR, 8'h00, 0, 0));
		send_request(make_req(REQ_PUSH, 8'h00, 0, 0));
		send_request(make_req(REQ_PUSH, 8'hFF, 8191, 16383));
		send_request(make_req(REQ_PEEK, 8'h00, 1, 0));
		send_request(make_req(REQ_PEEK, 8'h00, 2, 0));
		send_request(make_req(REQ_POP, 8'h00, 0, 0));
		send_request(make_req(REQ_POP, 8'h00, 0, 0));
		send_request(make_req(REQ_STAGE, 8'hA5, 8191, 0));
		send_request(make_req(REQ_STAGE, 8'h5A, 0, 0));
		// fill the ring in one move, then try to add more
		send_request(make_req(REQ_ADV_REAR, 8'h00, 0, 8192));
		send_request(make_req(REQ_PUSH, 8'h3C, 0, 0));
		send_request(make_req(REQ_STAGE, 8'hC3, 0, 0));
		send_request(make_req(REQ_UNUSED, 8'h00, 0, 0));
		send_request(make_req(REQ_PEEK, 8'h00, 0, 0));
		send_request(make_req(REQ_PEEK, 8'h00, 8191, 0));
		send_request(make_req(REQ_POP, 8'h00, 0, 0));
		// read pointer crosses the wrap point
		send_request(make_req(REQ_ADV_FRONT, 8'h00, 0, 8190));
		send_request(make_req(REQ_POP, 8'h00, 0, 0));
		send_request(make_req(REQ_CLEAR, 8'hFF, 8191, 8192));
		wait_drained();
	endtask

	// Bulk copies: stage a run of bytes, commit it, peek into it, consume it
	task automatic test_bulk_copy(input int n_items);
		int start_cnt;
		int run_len;
		int park;
		int k;
		start_cnt = requests_sent;
		send_request(make_req(REQ_CLEAR, $urandom, $urandom, $urandom));
		while (requests_sent - start_cnt < n_items) begin
			// park both pointers just short of the wrap point now and then
			if ($urandom_range(0, 7) == 0) begin
				send_request(make_req(REQ_CLEAR, $urandom, $urandom, 0));
				park = $urandom_range(RING_DEPTH - 40, RING_DEPTH - 1);
				send_request(make_req(REQ_ADV_REAR, $urandom, $urandom, park));
				send_request(make_req(REQ_ADV_FRONT, $urandom, $urandom, park));
			end
			run_len = $urandom_range(1, 24);
			if (RING_DEPTH - fill < run_len)
				send_request(make_req(REQ_ADV_FRONT, $urandom, $urandom, fill));
			for (k = 0; k < run_len; k++) begin
				if ($urandom_range(0, 1) == 0)
					send_request(make_req(REQ_STAGE, $urandom, k, $urandom));
				else
					send_request(make_req(REQ_STAGE, $urandom, run_len - 1 - k, $urandom));
			end
			send_request(make_req(REQ_ADV_REAR, $urandom, $urandom, run_len));
			repeat ($urandom_range(0, 3))
				send_request(make_req(REQ_PEEK, $urandom, $urandom_range(0, fill - 1), 0));
			k = $urandom_range(1, fill);
			if ($urandom_range(0, 1) == 0)
				repeat (k) send_request(make_req(REQ_POP, $urandom, $urandom, $urandom));
			else
				send_request(make_req(REQ_ADV_FRONT, $urandom, $urandom,
					k + $urandom_range(0, 2)));
		end
		wait_drained();
	endtask

	// Hold the result side off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		int k;
		req_gap_pct = 0;
		hold_cycles_req = HOLD_CYCLES;
		for (k = 0; k < 40; k++)
			send_request(random_request());
		req_gap_pct = IDLE_PCT;
		wait_drained();
	endtask

	// Random request mix; the middle stretch runs with no idling on either side
	task automatic test_random_mix(input int n_items);
		int k;
		for (k = 0; k < n_items; k++) begin
			if (k == n_items / 3) begin
				req_gap_pct = 0;
				res_stall_pct = 0;
			end else if (k == 2 * n_items / 3) begin
				req_gap_pct = IDLE_PCT;
				res_stall_pct = IDLE_PCT;
			end
			send_request(random_request());
		end
		wait_drained();
	endtask

	// Check each result taken and drive ready, with an occasional long hold
	always @(posedge clk) begin
		res_t due;
		if (res_valid && res_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result taken with no request outstanding");
				failures++;
			end else begin
				due = awaited_results.pop_front();
				check_field("data_out", due.data_out, res_data.data_out);
				check_field("done_res", due.done_res, res_data.done_res);
				check_field("moved", due.moved, res_data.moved);
				check_field("used_count", due.used_count, res_data.used_count);
				check_field("free_count", due.free_count, res_data.free_count);
				check_field("direct_enqueue", due.direct_enqueue, res_data.direct_enqueue);
				check_field("direct_dequeue", due.direct_dequeue, res_data.direct_dequeue);
			end
		end
		if (hold_cycles_req > 0) begin
			hold_left = hold_cycles_req;
			hold_cycles_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= res_stall_pct);
		end
	end

	// End the run if nothing moves on either side for too long
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[byte_ring_fifo] ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_bulk_copy(500);
		test_backpressure();
		test_random_mix(890);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && awaited_results.size() == 0) begin
			$display("[byte_ring_fifo] OK");
		end else begin
			$display("[byte_ring_fifo] ERROR");
		end
		$finish;
	end

endmodule
